// File: design/nsrc_pkg.sv
package nsrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_RUN   = 64;
  localparam int STEP_W    = 23;
  localparam int SAMPLE_W  = 16;
  localparam int CH_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int PH_W      = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS + 1) + 1;

  localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << FRAC_BITS;

  localparam logic [CH_W-1:0] CH_MONO = CH_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IN_IS_WIDE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_IS_WIDE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP    = CFG_IDX_W'(4);

  typedef struct packed {
    logic [SAMPLE_W-1:0] in_left;
    logic [SAMPLE_W-1:0] in_right;
    logic                end_of_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_left;
    logic [SAMPLE_W-1:0] out_right;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] in_channels;
    logic            in_is_wide;
    logic [CH_W-1:0] out_channels;
    logic            out_is_wide;
  } fmt_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                eos;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_link_t;

endpackage

// File: design/nsrc_front.sv
module nsrc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  nsrc_pkg::fmt_t    fmt,
  input  logic              push,
  output logic              full,
  input  nsrc_pkg::in_item_t in_item,
  output nsrc_pkg::job_link_t q_head,
  input  logic              q_pop
);
  import nsrc_pkg::*;

  job_t                q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] wide_l, wide_r;
  job_t                job_in;
  logic                do_push, do_pop;

  // widen to 16-bit stereo, then narrow to the output format
  always_comb begin
    wide_l = in_item.in_left;
    wide_r = in_item.in_right;
    if (!fmt.in_is_wide) begin
      wide_l = {in_item.in_left[7:0], 8'h00};
      wide_r = {in_item.in_right[7:0], 8'h00};
    end
    if (fmt.in_channels == CH_MONO) begin
      wide_r = wide_l;
    end
    job_in.left  = wide_l;
    job_in.right = wide_r;
    if (!fmt.out_is_wide) begin
      job_in.left  = {8'h00, wide_l[15:8]};
      job_in.right = {8'h00, wide_r[15:8]};
    end
    if (fmt.out_channels == CH_MONO) begin
      job_in.right = '0;
    end
    job_in.eos = in_item.end_of_sample;
  end

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = q_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= job_in;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.job   = q_mem[rd_ptr_r];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r != '0))
    else $error("queue popped while empty");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    full && !q_pop |=> full)
    else $error("queue left full state without a pop");

endmodule

// File: design/nsrc_back.sv
module nsrc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [nsrc_pkg::STEP_W-1:0] rate_step,
  input  nsrc_pkg::job_link_t  q_head,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output nsrc_pkg::out_item_t  out_item,
  output logic                 busy
);
  import nsrc_pkg::*;

  logic              busy_r, busy_nxt;
  job_t              job_r, job_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [RUN_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [PH_W-1:0]   sum;
  logic              no_out, can_emit, emit, last, finish, take;

  always_comb begin
    sum      = phase_r + PH_W'(rate_step);
    no_out   = (phase_r >= PHASE_ONE);
    can_emit = !out_valid_r || pop;
    emit     = busy_r && !no_out && can_emit;
    last     = (sum >= PHASE_ONE) || (cnt_r == RUN_W'(MAX_RUN - 1));
    finish   = busy_r && (no_out || (emit && last));
    take     = !busy_r && q_head.valid;
  end

  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (take) begin
      busy_nxt = 1'b1;
      job_nxt  = q_head.job;
      cnt_nxt  = '0;
    end
    if (emit) begin
      cnt_nxt   = cnt_r + RUN_W'(1);
      phase_nxt = sum;
    end
    if (finish) begin
      busy_nxt = 1'b0;
      if (job_r.eos) begin
        phase_nxt = '0;
      end else if (no_out) begin
        phase_nxt = phase_r - PHASE_ONE;
      end else if (sum >= PHASE_ONE) begin
        phase_nxt = sum - PHASE_ONE;
      end else begin
        // run limit hit before the frame was used up
        phase_nxt = '0;
      end
    end
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_nxt.out_left      = job_r.left;
      out_nxt.out_right     = job_r.right;
      out_nxt.last_of_run   = last;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  assign q_pop    = take;
  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign busy     = busy_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RUN_W'(MAX_RUN))
    else $error("run count beyond limit");

  a_limit_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (cnt_r == RUN_W'(MAX_RUN - 1)) |=> out_r.last_of_run)
    else $error("run limit reached without last flag");

  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    finish && job_r.eos |=> phase_r == '0)
    else $error("phase not cleared after end of sample");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> !busy_r)
    else $error("sequencer still busy after finishing a frame");

endmodule

// File: design/nearest_sample_rate_format_converter.sv
// path: queue, then sequencer job register, then output register to the output ports
// throughput: one result per cycle while a frame runs and pop keeps up; a frame causes
//   at most 64 results, and the next frame is taken only once the current one is done
// a 2-entry queue lets new frames transfer in while the sequencer runs
// reset: synchronous active-low rst_n clears phase, queue and output register,
//   and restores the default format and rate registers
module nearest_sample_rate_format_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  nsrc_pkg::in_item_t                  in_item,
  output logic                                empty,
  input  logic                                pop,
  output nsrc_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nsrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nsrc_pkg::STEP_W-1:0]         cfg_data
);
  import nsrc_pkg::*;

  fmt_t              fmt_r, fmt_nxt;
  logic [STEP_W-1:0] rate_step_r, rate_step_nxt;
  job_link_t         q_head;
  logic              q_pop;
  logic              back_busy;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    fmt_nxt       = fmt_r;
    rate_step_nxt = rate_step_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IN_CHANNELS:  fmt_nxt.in_channels  = cfg_data[CH_W-1:0];
        CFG_IN_IS_WIDE:   fmt_nxt.in_is_wide   = cfg_data[0];
        CFG_OUT_CHANNELS: fmt_nxt.out_channels = cfg_data[CH_W-1:0];
        CFG_OUT_IS_WIDE:  fmt_nxt.out_is_wide  = cfg_data[0];
        CFG_RATE_STEP:    rate_step_nxt        = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r.in_channels  <= CH_W'(2);
      fmt_r.in_is_wide   <= 1'b1;
      fmt_r.out_channels <= CH_W'(2);
      fmt_r.out_is_wide  <= 1'b1;
      rate_step_r        <= STEP_W'(65536);
    end else begin
      fmt_r       <= fmt_nxt;
      rate_step_r <= rate_step_nxt;
    end
  end

  nsrc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fmt     (fmt_r),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  nsrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rate_step (rate_step_r),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .busy      (back_busy)
  );

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> $stable(rate_step_r))
    ;

endmodule

// File: sim/nearest_sample_rate_format_converter_test.sv
module nearest_sample_rate_format_converter_test;
  import nsrc_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 800;
  localparam int STALL_LIMIT  = 4000;
  localparam int RUN_PHASES   = 8;
  localparam int FRAMES_PER_PHASE = 26;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);

  typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [STEP_W-1:0]    reg_data;
    in_item_t             frame;
    logic                 has_result;
    out_item_t            result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 40;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_FRAME, '0, '0, '{16'hffff, 16'h0000, 1'b0}, 1'b1, '{16'hffff, 16'h0000, 1'b1}},
    '{ROW_FRAME, '0, '0, '{16'h0000, 16'hffff, 1'b0}, 1'b1, '{16'h0000, 16'hffff, 1'b1}},
    '{ROW_FRAME, '0, '0, '{16'ha5c3, 16'h3c5a, 1'b1}, 1'b1, '{16'ha5c3, 16'h3c5a, 1'b1}},
    '{ROW_CFG, CFG_IN_IS_WIDE, 23'd0, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h12ab, 16'h34cd, 1'b0}, 1'b1, '{16'hab00, 16'hcd00, 1'b1}},
    '{ROW_CFG, CFG_IN_CHANNELS, 23'd1, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h00ff, 16'h1234, 1'b0}, 1'b1, '{16'hff00, 16'hff00, 1'b1}},
    '{ROW_CFG, CFG_OUT_IS_WIDE, 23'd0, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0080, 16'h5555, 1'b0}, 1'b1, '{16'h0080, 16'h0080, 1'b1}},
    '{ROW_CFG, CFG_OUT_CHANNELS, 23'd1, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h007f, 16'hffff, 1'b0}, 1'b1, '{16'h007f, 16'h0000, 1'b1}},
    // channel codes 0 and 3 behave as stereo
    '{ROW_CFG, CFG_IN_CHANNELS, 23'd0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_IN_IS_WIDE, 23'd1, '0, 1'b0, '0},
    '{ROW_CFG, CFG_OUT_CHANNELS, 23'd3, '0, 1'b0, '0},
    '{ROW_CFG, CFG_OUT_IS_WIDE, 23'd1, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h1234, 16'h5678, 1'b0}, 1'b1, '{16'h1234, 16'h5678, 1'b1}},
    '{ROW_CFG, CFG_RATE_STEP, 23'h008000, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h8001, 16'h7ffe, 1'b0}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h4242, 16'hbdbd, 1'b0}, 1'b0, '0},
    // downsampling, some frames emit nothing
    '{ROW_CFG, CFG_RATE_STEP, 23'h020000, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h1111, 16'h2222, 1'b0}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h3333, 16'h4444, 1'b0}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h5555, 16'h6666, 1'b0}, 1'b0, '0},
    '{ROW_CFG, CFG_RATE_STEP, 23'd1024, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'hc0de, 16'h0bad, 1'b0}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'hfeed, 16'hface, 1'b1}, 1'b0, '0},
    // run limit cuts the run short
    '{ROW_CFG, CFG_RATE_STEP, 23'd0, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0f0f, 16'hf0f0, 1'b0}, 1'b0, '0},
    '{ROW_CFG, CFG_RATE_STEP, 23'd700, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h9999, 16'h6666, 1'b0}, 1'b0, '0},
    '{ROW_CFG, CFG_RATE_STEP, 23'h7fffff, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0001, 16'h8000, 1'b0}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0002, 16'h4000, 1'b0}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0003, 16'h2000, 1'b1}, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0004, 16'h1000, 1'b0}, 1'b0, '0},
    '{ROW_CFG, CFG_SPARE_LO, 23'h012345, '0, 1'b0, '0},
    '{ROW_CFG, CFG_SPARE_HI, 23'h7fffff, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h0005, 16'h0800, 1'b0}, 1'b0, '0},
    '{ROW_CFG, CFG_RATE_STEP, 23'h010000, '0, 1'b0, '0},
    '{ROW_FRAME, '0, '0, '{16'h7e7e, 16'he7e7, 1'b1}, 1'b0, '0}
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  in_item_t             in_item   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data  = '0;

  nearest_sample_rate_format_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the format and rate registers
  logic [CH_W-1:0]   fmt_in_ch    = 2'd2;
  logic              fmt_in_wide  = 1'b1;
  logic [CH_W-1:0]   fmt_out_ch   = 2'd2;
  logic              fmt_out_wide = 1'b1;
  logic [STEP_W-1:0] rate         = 23'h010000;
  logic [STEP_W+1:0] next_pos     = '0;

  out_item_t run_frames[$];
  out_item_t expected_frames[$];

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_rx        = 1'b0;
  int   bad_frames     = 0;
  int   stall_cycles   = 0;

  function automatic void resample_frame(input in_item_t frame);
    logic [SAMPLE_W-1:0] l;
    logic [SAMPLE_W-1:0] r;
    out_item_t           o;
    int                  n;
    l = frame.in_left;
    r = frame.in_right;
    n = 0;
    if (!fmt_in_wide) begin
      l = {l[7:0], 8'h00};
      r = {r[7:0], 8'h00};
    end
    if (fmt_in_ch == CH_MONO) r = l;
    if (!fmt_out_wide) begin
      l = {8'h00, l[15:8]};
      r = {8'h00, r[15:8]};
    end
    if (fmt_out_ch == CH_MONO) r = '0;
    run_frames.delete();
    while (next_pos < PHASE_ONE && n < MAX_RUN) begin
      o.out_left    = l;
      o.out_right   = r;
      o.last_of_run = 1'b0;
      run_frames.push_back(o);
      n++;
      next_pos = next_pos + rate;
    end
    if (n > 0) run_frames[n-1].last_of_run = 1'b1;
    if (next_pos >= PHASE_ONE) next_pos = next_pos - PHASE_ONE;
    else next_pos = '0;
    if (frame.end_of_sample) next_pos = '0;
  endfunction

  function automatic in_item_t random_frame();
    in_item_t f;
    f.in_left       = SAMPLE_W'($urandom_range(0, 65535));
    f.in_right      = SAMPLE_W'($urandom_range(0, 65535));
    f.end_of_sample = ($urandom_range(0, 11) == 0);
    return f;
  endfunction

  task automatic send_frame(input in_item_t frame, input logic has_result,
                            input out_item_t result);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= frame;
    do @(posedge clk); while (full);
    resample_frame(frame);
    if (has_result) expected_frames.push_back(result);
    else foreach (run_frames[i]) expected_frames.push_back(run_frames[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IN_CHANNELS:  fmt_in_ch    = val[CH_W-1:0];
      CFG_IN_IS_WIDE:   fmt_in_wide  = val[0];
      CFG_OUT_CHANNELS: fmt_out_ch   = val[CH_W-1:0];
      CFG_OUT_IS_WIDE:  fmt_out_wide = val[0];
      CFG_RATE_STEP:    rate         = val;
      default: ;
    endcase
  endtask

  // stop offering frames until the block has gone quiet
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receive side: compare, then pick the next pop
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_frames.size() == 0) begin
        if (bad_frames < 10)
          $display("unexpected output frame: left %h right %h last %b",
                   out_item.out_left, out_item.out_right, out_item.last_of_run);
        bad_frames++;
      end else begin
        want = expected_frames.pop_front();
        if (out_item.out_left !== want.out_left || out_item.out_right !== want.out_right ||
            out_item.last_of_run !== want.last_of_run) begin
          if (bad_frames < 10)
            $display("output mismatch: expected left %h right %h last %b, got %h %h %b",
                     want.out_left, want.out_right, want.last_of_run,
                     out_item.out_left, out_item.out_right, out_item.last_of_run);
          bad_frames++;
        end
      end
    end
    pop <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** nearest_sample_rate_format_converter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [STEP_W-1:0] step;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_data);
      end else begin
        cfg_valid <= 1'b0;
        send_frame(DIRECTED[i].frame, DIRECTED[i].has_result, DIRECTED[i].result);
      end
    end
    cfg_valid <= 1'b0;

    for (int p = 0; p < RUN_PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      case (p)
        0: step = STEP_W'($urandom_range(32'h4000, 32'h10000));
        1: step = STEP_W'(1024);
        2: step = STEP_W'($urandom_range(1024, 32'h20000));
        3: step = STEP_W'(4194304);
        4: step = STEP_W'($urandom_range(0, 32'h7fffff));
        5: step = STEP_W'($urandom_range(0, 1023));
        default: step = STEP_W'($urandom_range(32'h2000, 32'h30000));
      endcase
      write_reg(CFG_IN_CHANNELS, STEP_W'($urandom_range(0, 3)));
      write_reg(CFG_IN_IS_WIDE, STEP_W'($urandom_range(0, 1)));
      write_reg(CFG_OUT_CHANNELS, STEP_W'($urandom_range(0, 3)));
      write_reg(CFG_OUT_IS_WIDE, STEP_W'($urandom_range(0, 1)));
      write_reg(CFG_RATE_STEP, step);
      cfg_valid <= 1'b0;

      if (p == 0) begin
        // receiver holds off long enough for the input to back up
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
          for (int n = 0; n < FRAMES_PER_PHASE; n++) send_frame(random_frame(), 1'b0, '0);
        join
      end else begin
        for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
          if (p == 2 && n == FRAMES_PER_PHASE / 2) wait_drained();
          send_frame(random_frame(), 1'b0, '0);
        end
      end
    end

    wait_drained();
    if (bad_frames == 0) begin
      $display("** nearest_sample_rate_format_converter: PASSED **");
    end else begin
      $display("** nearest_sample_rate_format_converter: FAILED **");
    end
    $finish;
  end

endmodule
